/* rtl/core/world_inverse_inertia_tensor_assert.svh */
`ifndef WORLD_INVERSE_INERTIA_TENSOR_ASSERT_SVH
`define WORLD_INVERSE_INERTIA_TENSOR_ASSERT_SVH

// Sampled on clk, off while rst is high.
`define WIIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Sampled on clk, also checked across reset.
`define WIIT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/wiit_pkg.sv */
package wiit_pkg;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [31:0] q16_t;
  typedef logic signed [31:0] q28_t;

  typedef struct packed {
    q14_t quat_w;
    q14_t quat_x;
    q14_t quat_y;
    q14_t quat_z;
  } quat_t;

  typedef struct packed {
    q16_t tensor_xx;
    q16_t tensor_yy;
    q16_t tensor_zz;
    q16_t tensor_xy;
    q16_t tensor_xz;
    q16_t tensor_yz;
  } tensor_t;

  typedef q28_t [2:0][2:0] rmat_t;
  typedef logic [2:0][31:0] diag_t;

  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

  localparam logic [1:0] CFG_INV_INERTIA_X = 2'd0;
  localparam logic [1:0] CFG_INV_INERTIA_Y = 2'd1;
  localparam logic [1:0] CFG_INV_INERTIA_Z = 2'd2;

  localparam logic [31:0] INV_INERTIA_RESET = 32'h0001_0000;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  function automatic q16_t sat32(input logic signed [63:0] v);
    q16_t res;
    if (v > SAT_MAX) begin
      res = 32'sh7fff_ffff;
    end else if (v < SAT_MIN) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/wiit_queue.sv */
module wiit_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* rtl/core/wiit_rotmat.sv */
module wiit_rotmat (
  input  logic                clk,
  input  logic                rst,
  input  wiit_pkg::pipe_ctl_t ctl,
  input  wiit_pkg::quat_t     quat,
  output logic                vld,
  output wiit_pkg::rmat_t     rmat
);
  import wiit_pkg::*;

  localparam logic signed [35:0] ONE_Q28 = 36'sh010000000;

  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [35:0] r_full [3][3];
  rmat_t              rmat_next;
  logic               vld1;

  assign qw = $signed(quat.quat_w);
  assign qx = $signed(quat.quat_x);
  assign qy = $signed(quat.quat_y);
  assign qz = $signed(quat.quat_z);

  assign r_full[0][0] = ONE_Q28 - ((36'(yy) + 36'(zz)) <<< 1);
  assign r_full[0][1] = (36'(xy) - 36'(wz)) <<< 1;
  assign r_full[0][2] = (36'(xz) + 36'(wy)) <<< 1;
  assign r_full[1][0] = (36'(xy) + 36'(wz)) <<< 1;
  assign r_full[1][1] = ONE_Q28 - ((36'(xx) + 36'(zz)) <<< 1);
  assign r_full[1][2] = (36'(yz) - 36'(wx)) <<< 1;
  assign r_full[2][0] = (36'(xz) - 36'(wy)) <<< 1;
  assign r_full[2][1] = (36'(yz) + 36'(wx)) <<< 1;
  assign r_full[2][2] = ONE_Q28 - ((36'(xx) + 36'(yy)) <<< 1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rmat_next[i][j] = sat32(64'(r_full[i][j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld  <= 1'b0;
    end else if (ctl.adv) begin
      vld1 <= ctl.vld;
      vld  <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      xx   <= qx * qx;
      yy   <= qy * qy;
      zz   <= qz * qz;
      xy   <= qx * qy;
      xz   <= qx * qz;
      yz   <= qy * qz;
      wx   <= qw * qx;
      wy   <= qw * qy;
      wz   <= qw * qz;
      rmat <= rmat_next;
    end
  end

endmodule

/* rtl/core/wiit_tensor.sv */
module wiit_tensor (
  input  logic                clk,
  input  logic                rst,
  input  wiit_pkg::pipe_ctl_t ctl,
  input  wiit_pkg::rmat_t     rmat,
  input  wiit_pkg::diag_t     diag,
  output logic                vld,
  output wiit_pkg::tensor_t   tensor
);
  import wiit_pkg::*;

  localparam int NEL = 6;
  localparam int ROW [NEL] = '{0, 1, 2, 0, 0, 1};
  localparam int COL [NEL] = '{0, 1, 2, 1, 2, 2};
  localparam logic signed [63:0] HALF_P = 64'sd33554432;
  localparam logic signed [71:0] HALF_T = 72'sd536870912;

  logic [3:0]         vld_sr;
  logic signed [63:0] prod   [NEL][3];
  logic signed [37:0] p30    [NEL][3];
  logic signed [54:0] mul_hi [NEL][3];
  logic signed [54:0] mul_lo [NEL][3];
  logic signed [71:0] t_sum  [NEL][3];
  logic signed [39:0] term   [NEL][3];
  logic signed [41:0] e_sum  [NEL];
  logic signed [16:0] d_hi   [3];
  logic signed [16:0] d_lo   [3];
  q16_t               elem   [NEL];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_hi[k] = $signed({1'b0, diag[k][31:16]});
      d_lo[k] = $signed({1'b0, diag[k][15:0]});
    end
    for (int e = 0; e < NEL; e++) begin
      for (int k = 0; k < 3; k++) begin
        t_sum[e][k] = (72'(mul_hi[e][k]) <<< 16) + 72'(mul_lo[e][k]) + HALF_T;
      end
      e_sum[e] = 42'(term[e][0]) + 42'(term[e][1]) + 42'(term[e][2]);
      elem[e]  = sat32(64'(e_sum[e]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
      vld    <= 1'b0;
    end else if (ctl.adv) begin
      vld_sr <= {vld_sr[2:0], ctl.vld};
      vld    <= vld_sr[3];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int e = 0; e < NEL; e++) begin
        for (int k = 0; k < 3; k++) begin
          prod[e][k]   <= $signed(rmat[ROW[e]][k]) * $signed(rmat[COL[e]][k]);
          p30[e][k]    <= 38'((prod[e][k] + HALF_P) >>> 26);
          mul_hi[e][k] <= p30[e][k] * d_hi[k];
          mul_lo[e][k] <= p30[e][k] * d_lo[k];
          term[e][k]   <= 40'(t_sum[e][k] >>> 30);
        end
      end
      tensor.tensor_xx <= elem[0];
      tensor.tensor_yy <= elem[1];
      tensor.tensor_zz <= elem[2];
      tensor.tensor_xy <= elem[3];
      tensor.tensor_xz <= elem[4];
      tensor.tensor_yz <= elem[5];
    end
  end

endmodule

/* rtl/core/world_inverse_inertia_tensor.sv */
// World-space inverse inertia tensor R*diag(ix,iy,iz)*R^T from a Q1.14 quaternion.
// Input channel: push/full with quat (w, x, y, z); a transfer happens when push
// is high and full is low. Result channel: empty/pop with tensor (six unique
// elements, signed Q16.16, saturated); the head result is valid while empty is
// low and transfers when pop is high.
// Config: cfg_we/cfg_index/cfg_data write inv_inertia_x/y/z (index 0..2,
// unsigned Q16.16); index 3 is ignored. Write only while the block is idle.
// Path from input transfer to empty going low: the input queue, the rotation-matrix
// stages, the tensor stages and the result queue.
// Throughput: one item per cycle unless stalled (fully pipelined multiplier stages).
// Reset clears both queues and the pipeline and sets all three diagonal values
// to 1.0.
// Stall: when the result queue is full and the last stage holds a result, the
// whole pipeline freezes; the input queue then fills and raises full.
module world_inverse_inertia_tensor #(
  parameter int IN_DEPTH  = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  wiit_pkg::quat_t   quat,
  output logic              empty,
  input  logic              pop,
  output wiit_pkg::tensor_t tensor,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import wiit_pkg::*;

  logic [$bits(quat_t)-1:0]   in_rdata;
  logic [$bits(tensor_t)-1:0] out_rdata;
  quat_t                      in_item;
  logic                       in_empty;
  logic                       in_take;
  logic                       adv;
  pipe_ctl_t                  rot_ctl;
  pipe_ctl_t                  xf_ctl;
  logic                       rot_vld;
  logic                       xf_vld;
  logic                       out_full;
  rmat_t                      rmat;
  tensor_t                    xf_out;
  diag_t                      diag;

  always_ff @(posedge clk) begin
    if (rst) begin
      diag[0] <= INV_INERTIA_RESET;
      diag[1] <= INV_INERTIA_RESET;
      diag[2] <= INV_INERTIA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INV_INERTIA_X: diag[0] <= cfg_data;
        CFG_INV_INERTIA_Y: diag[1] <= cfg_data;
        CFG_INV_INERTIA_Z: diag[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv     = !(xf_vld && out_full);
  assign in_take = adv && !in_empty;
  assign in_item = in_rdata;
  assign rot_ctl = '{adv: adv, vld: in_take};
  assign xf_ctl  = '{adv: adv, vld: rot_vld};
  assign tensor  = out_rdata;

  wiit_queue #(
    .WIDTH ($bits(quat_t)),
    .DEPTH (IN_DEPTH)
  ) u_in_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (quat),
    .full  (full),
    .pop   (in_take),
    .rdata (in_rdata),
    .empty (in_empty)
  );

  wiit_rotmat u_rotmat (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rot_ctl),
    .quat (in_item),
    .vld  (rot_vld),
    .rmat (rmat)
  );

  wiit_tensor u_tensor (
    .clk    (clk),
    .rst    (rst),
    .ctl    (xf_ctl),
    .rmat   (rmat),
    .diag   (diag),
    .vld    (xf_vld),
    .tensor (xf_out)
  );

  wiit_queue #(
    .WIDTH ($bits(tensor_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (adv && xf_vld),
    .wdata (xf_out),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

endmodule

/* rtl/core/wiit_check.sv */
`include "world_inverse_inertia_tensor_assert.svh"

module wiit_check (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input wiit_pkg::tensor_t tensor
);

  `WIIT_ASSERT_RST(a_reset_clears, rst |=> (empty && !full), "queues not clear after reset")

  // input side backs up only behind a waiting result
  `WIIT_ASSERT(a_full_needs_stall, $rose(full) |-> $past(!empty), "full without result backlog")

  `WIIT_ASSERT(a_result_holds, (!empty && !pop) |=> !empty, "waiting result dropped")

  `WIIT_ASSERT(a_payload_holds, (!empty && !pop) |=> $stable(tensor), "waiting result changed")

endmodule

bind world_inverse_inertia_tensor wiit_check u_check (.*);
